// ----- hw/rtl/yrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// yrgb_pkg
// Shared types, coefficients and helpers of the YUYV 4:2:2 to RGB888 unit.
// ----------------------------------------------------------------------------
package yrgb_pkg;

  // Q16 coefficients, kept signed with one spare bit for the multiplies
  localparam int COEF_W = 18;
  localparam logic signed [COEF_W-1:0] COEF_RV = 18'sd92242;
  localparam logic signed [COEF_W-1:0] COEF_GU = 18'sd22643;
  localparam logic signed [COEF_W-1:0] COEF_GV = 18'sd46983;
  localparam logic signed [COEF_W-1:0] COEF_BU = 18'sd116589;

  localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;
  localparam logic [7:0]        CHAN_MAX      = 8'd255;

  // Q16 sums: 24-bit luma term plus a chroma term under 2^24, with sign
  localparam int SUM_W = 27;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_PAIRS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;
  localparam int CFG_DATA_W     = 11;
  localparam int WIDTH_REG_W    = 10;
  localparam int HEIGHT_REG_W   = 11;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_PAIRS_RESET  = 10'd160;
  localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RESET = 11'd240;

  typedef struct packed {
    logic [7:0] luma_even;
    logic [7:0] chroma_u;
    logic [7:0] luma_odd;
    logic [7:0] chroma_v;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_even;
    logic [7:0] green_even;
    logic [7:0] blue_even;
    logic [7:0] red_odd;
    logic [7:0] green_odd;
    logic [7:0] blue_odd;
    logic       row_end;
    logic       frame_end;
  } out_word_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] red;
    logic signed [SUM_W-1:0] green;
    logic signed [SUM_W-1:0] blue;
  } chroma_terms_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic row_last;
    logic frame_last;
  } pos_flags_t;

  // Negative -> 0, floor the Q16 sum, saturate at 255
  function automatic logic [7:0] clamp_q16(input logic signed [SUM_W-1:0] sum);
    logic [7:0] res;
    if (sum[SUM_W-1]) begin
      res = 8'd0;
    end else if (|sum[SUM_W-2:24]) begin
      res = CHAN_MAX;
    end else begin
      res = sum[23:16];
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/yrgb_chroma.sv -----
// ----------------------------------------------------------------------------
// yrgb_chroma
// Chroma products shared by both pixels of a pair (constant multiplies).
// ----------------------------------------------------------------------------
module yrgb_chroma
  import yrgb_pkg::*;
(
  input  logic [7:0]    chroma_u,
  input  logic [7:0]    chroma_v,
  output chroma_terms_t terms
);

  logic signed [8:0] u_c;
  logic signed [8:0] v_c;
  logic signed [SUM_W-1:0] u_ext;
  logic signed [SUM_W-1:0] v_ext;

  assign u_c   = $signed({1'b0, chroma_u}) - CHROMA_OFFSET;
  assign v_c   = $signed({1'b0, chroma_v}) - CHROMA_OFFSET;
  assign u_ext = SUM_W'(u_c);
  assign v_ext = SUM_W'(v_c);

  // all products fit well inside SUM_W bits
  assign terms.red   = SUM_W'(COEF_RV * v_ext);
  assign terms.green = SUM_W'(-(COEF_GU * u_ext) - (COEF_GV * v_ext));
  assign terms.blue  = SUM_W'(COEF_BU * u_ext);

endmodule

// ----- hw/rtl/yrgb_pixel.sv -----
// ----------------------------------------------------------------------------
// yrgb_pixel
// Adds one luma to the shared chroma terms and clamps each channel.
// ----------------------------------------------------------------------------
module yrgb_pixel
  import yrgb_pkg::*;
(
  input  logic [7:0]    luma,
  input  chroma_terms_t terms,
  output rgb_t          rgb
);

  logic signed [SUM_W-1:0] base;

  assign base = $signed({3'b000, luma, 16'h0000});

  assign rgb.red   = clamp_q16(base + terms.red);
  assign rgb.green = clamp_q16(base + terms.green);
  assign rgb.blue  = clamp_q16(base + terms.blue);

endmodule

// ----- hw/rtl/yrgb_position.sv -----
// ----------------------------------------------------------------------------
// yrgb_position
// Size registers plus pair/row counters; flags the last pair of row and frame.
// ----------------------------------------------------------------------------
module yrgb_position
  import yrgb_pkg::*;
#(
  parameter int MAX_WIDTH_PAIRS = 512,
  parameter int MAX_HEIGHT      = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  step,
  output pos_flags_t            flags
);

  localparam int COL_W  = (MAX_WIDTH_PAIRS > 1) ? $clog2(MAX_WIDTH_PAIRS) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WLIM_W = ($clog2(MAX_WIDTH_PAIRS + 1) > WIDTH_REG_W) ?
                          $clog2(MAX_WIDTH_PAIRS + 1) : WIDTH_REG_W;
  localparam int HLIM_W = ($clog2(MAX_HEIGHT + 1) > HEIGHT_REG_W) ?
                          $clog2(MAX_HEIGHT + 1) : HEIGHT_REG_W;
  localparam int WCMP_W = ((WLIM_W > COL_W) ? WLIM_W : COL_W) + 1;
  localparam int HCMP_W = ((HLIM_W > ROW_W) ? HLIM_W : ROW_W) + 1;

  logic [WIDTH_REG_W-1:0]  width_pairs;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [COL_W-1:0]        pair_column;
  logic [ROW_W-1:0]        row_index;
  logic [WCMP_W-1:0]       wlim;
  logic [HCMP_W-1:0]       hlim;
  logic [WCMP_W-1:0]       col_plus;
  logic [HCMP_W-1:0]       row_plus;

  // zero means one, oversize saturates
  always_comb begin
    if (width_pairs == '0) begin
      wlim = WCMP_W'(1);
    end else if (WCMP_W'(width_pairs) > WCMP_W'(MAX_WIDTH_PAIRS)) begin
      wlim = WCMP_W'(MAX_WIDTH_PAIRS);
    end else begin
      wlim = WCMP_W'(width_pairs);
    end
    if (image_height == '0) begin
      hlim = HCMP_W'(1);
    end else if (HCMP_W'(image_height) > HCMP_W'(MAX_HEIGHT)) begin
      hlim = HCMP_W'(MAX_HEIGHT);
    end else begin
      hlim = HCMP_W'(image_height);
    end
  end

  assign col_plus         = WCMP_W'(pair_column) + WCMP_W'(1);
  assign row_plus         = HCMP_W'(row_index) + HCMP_W'(1);
  assign flags.row_last   = col_plus >= wlim;
  assign flags.frame_last = flags.row_last && (row_plus >= hlim);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_pairs  <= WIDTH_PAIRS_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WIDTH_PAIRS:  width_pairs  <= cfg_data[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_column <= '0;
      row_index   <= '0;
    end else if (step) begin
      if (flags.row_last) begin
        pair_column <= '0;
        row_index   <= flags.frame_last ? '0 : row_plus[ROW_W-1:0];
      end else begin
        pair_column <= col_plus[COL_W-1:0];
      end
    end
  end

endmodule

// ----- hw/rtl/yuyv422_to_rgb888_unit.sv -----
// ----------------------------------------------------------------------------
// yuyv422_to_rgb888_unit
// YUYV 4:2:2 macro-pixel to two RGB888 pixels, BT.601-style coefficients.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+----------------------------
//  in      | input     | in_valid / in_stall  | in_word  (Y0, U, Y1, V)
//  out     | output    | out_valid / out_stall| out_word (RGB even, RGB odd,
//          |           |                      |           row_end, frame_end)
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
//  One word per cycle sustained while out_stall is low; each word passes the
//  input register, then the result register after the multiply/clamp pass.
//  Row and frame flags are taken from the pair/row counters when the word
//  is accepted.
//  Synchronous reset: pipeline empty, counters zero, sizes 160 x 240.
//  out_stall holds the result register; the input register keeps accepting
//  while it is free, so a waiting result does not block the next word.
//
module yuyv422_to_rgb888_unit
  import yrgb_pkg::*;
#(
  parameter int MAX_WIDTH_PAIRS = 512,
  parameter int MAX_HEIGHT      = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  // result words
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word
);

  // stage 1: captured input word plus its position flags
  logic          s1_valid;
  in_word_t      s1_word;
  pos_flags_t    s1_flags;
  // stage 2: result register
  logic          s2_valid;
  out_word_t     s2_word;

  logic          s2_load;
  logic          s1_load;
  logic          accept;
  pos_flags_t    pos_flags;
  chroma_terms_t terms;
  rgb_t          rgb_even;
  rgb_t          rgb_odd;

  // result register frees up when empty or being taken this cycle
  assign s2_load  = s1_valid && (!s2_valid || !out_stall);
  assign s1_load  = !s1_valid || s2_load;
  assign in_stall = !s1_load;
  assign accept   = in_valid && !in_stall;

  yrgb_position #(
    .MAX_WIDTH_PAIRS(MAX_WIDTH_PAIRS),
    .MAX_HEIGHT     (MAX_HEIGHT)
  ) u_position (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .step     (accept),
    .flags    (pos_flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word  <= in_word;
      s1_flags <= pos_flags;
    end
  end

  // chroma products shared by both pixels, then per-pixel add and clamp
  yrgb_chroma u_chroma (
    .chroma_u(s1_word.chroma_u),
    .chroma_v(s1_word.chroma_v),
    .terms   (terms)
  );

  yrgb_pixel u_pixel_even (
    .luma (s1_word.luma_even),
    .terms(terms),
    .rgb  (rgb_even)
  );

  yrgb_pixel u_pixel_odd (
    .luma (s1_word.luma_odd),
    .terms(terms),
    .rgb  (rgb_odd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (!out_stall) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_word.red_even   <= rgb_even.red;
      s2_word.green_even <= rgb_even.green;
      s2_word.blue_even  <= rgb_even.blue;
      s2_word.red_odd    <= rgb_odd.red;
      s2_word.green_odd  <= rgb_odd.green;
      s2_word.blue_odd   <= rgb_odd.blue;
      s2_word.row_end    <= s1_flags.row_last;
      s2_word.frame_end  <= s1_flags.frame_last;
    end
  end

  assign out_valid = s2_valid;
  assign out_word  = s2_word;

  // a frame always ends on a row end
  a_frame_on_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_word.frame_end || out_word.row_end))
    else $error("frame_end without row_end");

  // an empty input register never stalls the input
  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled while input register empty");

  // a word moving into the result register shows up next cycle
  a_s1_to_out: assert property (@(posedge clk) disable iff (rst)
    s2_load |=> out_valid)
    else $error("result lost between stages");

  // results only come from the input register
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !s1_valid) |=> !out_valid)
    else $error("result appeared without a source word");

endmodule

// ----- tb/tb_yuyv422_to_rgb888_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yuyv422_to_rgb888_unit
// Self-checking bench for the YUYV 4:2:2 to RGB888 unit. A queue-fed driver
// offers macro-pixel words, a local Q16 converter plus pair/row counters
// predicts every result word, and a monitor checks each one in order.
// The run steps through several frame sizes (zero, minimum, saturated,
// shrunk mid-row and mid-frame) with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_yuyv422_to_rgb888_unit;
  import yrgb_pkg::*;

  localparam int MAX_W = 512;
  localparam int MAX_H = 1024;

  // Q16 coefficients of the converter, rounded to nearest
  localparam longint K_RV = 92242;
  localparam longint K_GU = 22643;
  localparam longint K_GV = 46983;
  localparam longint K_BU = 116589;

  localparam int IDLE_PCT     = 35;   // idle share of each side, in percent
  localparam int HOLDOFF_LEN  = 80;   // long receiver hold-off, cycles
  localparam int DRAIN_CYCLES = 4;    // two-stage pipe plus margin
  localparam int WATCHDOG_MAX = 2000; // cycles with no word moving
  localparam int REPORT_MAX   = 10;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_WIDTH_PAIRS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;

  yuyv422_to_rgb888_unit #(
    .MAX_WIDTH_PAIRS(MAX_W),
    .MAX_HEIGHT     (MAX_H)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_word_t  pend_words[$];  // macro-pixels waiting to be offered
  out_word_t rgb_expect[$];  // predicted result words, oldest first

  // No-idle window; set by the stimulus at a falling edge
  bit calm = 1'b0;
  int mismatch_cnt = 0;

  // Predictor copy of the registers and counters
  logic [WIDTH_REG_W-1:0]  pred_width  = WIDTH_PAIRS_RESET;
  logic [HEIGHT_REG_W-1:0] pred_height = IMAGE_HEIGHT_RESET;
  int unsigned             pair_col    = 0;
  int unsigned             row_cnt     = 0;

  // Negative -> 0, drop the 16 fraction bits, saturate at 255
  function automatic logic [7:0] sat_chan(input longint s);
    logic [7:0] c;
    if (s < 0) begin
      c = 8'd0;
    end else if (s >= 64'sd16777216) begin
      c = 8'd255;
    end else begin
      c = s[23:16];
    end
    return c;
  endfunction

  function automatic rgb_t pixel_rgb(input logic [7:0] y, input longint u, input longint v);
    rgb_t   p;
    longint base;
    base    = longint'(y) * 65536;
    p.red   = sat_chan(base + K_RV * v);
    p.green = sat_chan(base - K_GU * u - K_GV * v);
    p.blue  = sat_chan(base + K_BU * u);
    return p;
  endfunction

  // 0 counts as 1, oversize clips to the build maximum
  function automatic int unsigned size_limit(input int unsigned value, input int unsigned top);
    int unsigned lim;
    if (value == 0) begin
      lim = 1;
    end else if (value > top) begin
      lim = top;
    end else begin
      lim = value;
    end
    return lim;
  endfunction

  // Converts one pair and advances the column/row counters
  task automatic convert_and_count(input in_word_t w, output out_word_t r);
    longint      u, v;
    rgb_t        pe, po;
    int unsigned wlim, hlim;
    u    = longint'(w.chroma_u) - 128;
    v    = longint'(w.chroma_v) - 128;
    pe   = pixel_rgb(w.luma_even, u, v);
    po   = pixel_rgb(w.luma_odd, u, v);
    wlim = size_limit(32'(pred_width), MAX_W);
    hlim = size_limit(32'(pred_height), MAX_H);
    r.red_even   = pe.red;
    r.green_even = pe.green;
    r.blue_even  = pe.blue;
    r.red_odd    = po.red;
    r.green_odd  = po.green;
    r.blue_odd   = po.blue;
    r.row_end    = 1'b0;
    r.frame_end  = 1'b0;
    // >= rather than == so a counter past a shrunk limit ends at once
    if (pair_col + 1 >= wlim) begin
      r.row_end = 1'b1;
      pair_col  = 0;
      if (row_cnt + 1 >= hlim) begin
        r.frame_end = 1'b1;
        row_cnt     = 0;
      end else begin
        row_cnt = row_cnt + 1;
      end
    end else begin
      pair_col = pair_col + 1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer the next pending word unless idling; hold while stalled.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pend_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_word  <= pend_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: random idling, plus one long hold-off at the start of
  // the calm phase so the pipe fills and backs up into in_stall.
  // --------------------------------------------------------------------------
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall    <= 1'b1;
    end else if (calm && !holdoff_done && in_valid) begin
      holdoff_done <= 1'b1;
      holdoff_left <= HOLDOFF_LEN;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Scoreboard: check the result word, then predict from the accepted input
  // word. Register writes update the predictor copy at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t exp_w;
    out_word_t got_w;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got_w = out_word;
        if (rgb_expect.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $display("unexpected result word %h at %0t", got_w, $realtime);
          end
        end else begin
          exp_w = rgb_expect.pop_front();
          if (got_w.red_even !== exp_w.red_even || got_w.green_even !== exp_w.green_even ||
              got_w.blue_even !== exp_w.blue_even || got_w.red_odd !== exp_w.red_odd ||
              got_w.green_odd !== exp_w.green_odd || got_w.blue_odd !== exp_w.blue_odd ||
              got_w.row_end !== exp_w.row_end || got_w.frame_end !== exp_w.frame_end) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX) begin
              $display("mismatch at %0t: exp rgb0 %h %h %h rgb1 %h %h %h row %b frame %b",
                       $realtime, exp_w.red_even, exp_w.green_even, exp_w.blue_even,
                       exp_w.red_odd, exp_w.green_odd, exp_w.blue_odd,
                       exp_w.row_end, exp_w.frame_end);
              $display("                 got rgb0 %h %h %h rgb1 %h %h %h row %b frame %b",
                       got_w.red_even, got_w.green_even, got_w.blue_even,
                       got_w.red_odd, got_w.green_odd, got_w.blue_odd,
                       got_w.row_end, got_w.frame_end);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        convert_and_count(in_word, exp_w);
        rgb_expect.push_back(exp_w);
      end
      if (cfg_write) begin
        if (cfg_index == CFG_WIDTH_PAIRS) begin
          pred_width = cfg_data[WIDTH_REG_W-1:0];  // bits above the register drop
        end else if (cfg_index == CFG_IMAGE_HEIGHT) begin
          pred_height = cfg_data[HEIGHT_REG_W-1:0];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: only counts while work is outstanding.
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (pend_words.size() == 0 && !in_valid && rgb_expect.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Directed pairs {Y0, U, Y1, V}: extremes, neutral gray and each clamp
  logic [31:0] directed_words [0:17] = '{
    32'h00000000, 32'hFFFFFFFF, 32'hFF8000_80, 32'h0080FF80,
    32'hFF80FFFF, 32'h00800000, 32'h80008080, 32'h80FF8080,
    32'h80808000, 32'h80FF80FF, 32'h1080EB80, 32'hFF0000FF,
    32'h00FFFF00, 32'h7F7F8081, 32'h01FEFE01, 32'hAA5555AA,
    32'h55AAAA55, 32'h80808080
  };

  // Mostly uniform bytes, some pinned to the clamp corners or to neutral 0x80
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(9))
      0:       b = 8'h00;
      1:       b = 8'hFF;
      2:       b = 8'h80;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pend_words.size() != 0 || in_valid || rgb_expect.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Resize between phases; counters carry over, so shrinks land mid-row
  task automatic run_phase(input logic [CFG_DATA_W-1:0] w_val,
                           input logic [CFG_DATA_W-1:0] h_val,
                           input int n, input bit no_idle);
    in_word_t w;
    wait_drained();
    write_reg(CFG_WIDTH_PAIRS, w_val);
    write_reg(CFG_IMAGE_HEIGHT, h_val);
    @(negedge clk);
    calm = no_idle;
    for (int i = 0; i < n; i++) begin
      w.luma_even = pick_byte();
      w.chroma_u  = pick_byte();
      w.luma_odd  = pick_byte();
      w.chroma_v  = pick_byte();
      pend_words.push_back(w);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset sizes 160 x 240: leaves the column counter mid-row
    foreach (directed_words[i]) pend_words.push_back(in_word_t'(directed_words[i]));

    run_phase(11'd3,    11'd2047, 40,  1'b0);  // narrower than the column; height clips
    run_phase(11'd1,    11'd50,   30,  1'b0);  // one pair per row, rows climb
    run_phase(11'd2,    11'd4,    40,  1'b0);  // row counter past the new height
    run_phase(11'd0,    11'd0,    40,  1'b0);  // zero sizes act as one
    run_phase(11'h400,  11'd3,    40,  1'b0);  // width bit 10 ignored -> zero
    run_phase(11'd5,    11'd3,    100, 1'b1);  // no idling, long hold-off
    run_phase(11'h7FF,  11'd1024, 40,  1'b0);  // largest sizes
    run_phase(11'd7,    11'd2,    100, 1'b0);
    run_phase(11'd1,    11'd1,    20,  1'b0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && rgb_expect.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/yrgb_pkg.sv
hw/rtl/yrgb_chroma.sv
hw/rtl/yrgb_pixel.sv
hw/rtl/yrgb_position.sv
hw/rtl/yuyv422_to_rgb888_unit.sv
tb/tb_yuyv422_to_rgb888_unit.sv
